[rtl/tptw_pkg.sv]
// Shared types, codes and field layout for the track position to world unit.
// No dependencies; top, controller and datapath refer to it by scoped names.
`default_nettype none
package tptw_pkg;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 7;
    localparam int SEG_W   = 6;
    localparam int SEL_W   = 4;
    localparam int OP_W    = 2;
    localparam int SUM_W   = 40;
    localparam int ACC_W   = 64;

    // slave tdata: seg_index, word_sel, word_data, along, lateral, height
    localparam int S_TDATA_W = 144;
    localparam int S_SEG_LO  = 0;
    localparam int S_SEL_LO  = 6;
    localparam int S_DATA_LO = 10;
    localparam int S_ALNG_LO = 42;
    localparam int S_LAT_LO  = 74;
    localparam int S_HGT_LO  = 106;

    // master tdata: vec_x, vec_y, vec_z, found_segment, pad
    localparam int M_TDATA_W = 104;
    localparam int M_PAD_W   = M_TDATA_W - 3 * DATA_W - IDX_W;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_POS    = 2'd1;
    localparam logic [OP_W-1:0] OP_ORIENT = 2'd2;

    localparam logic [SEL_W-1:0] SEL_LENGTH = 4'd0;
    localparam logic [SEL_W-1:0] SEL_ORIGIN = 4'd1;
    localparam logic [SEL_W-1:0] SEL_AXIS   = 4'd4;
    localparam logic [SEL_W-1:0] SEL_LAST   = 4'd12;

    localparam logic [1:0] OUT_OOR  = 2'd0;
    localparam logic [1:0] OUT_POS  = 2'd1;
    localparam logic [1:0] OUT_AXIS = 2'd2;

    localparam logic [3:0] LAST_TERM = 4'd8;
    localparam logic [1:0] LAST_AXIS = 2'd2;

    typedef struct packed {
        logic       write;
        logic       start;
        logic       is_orient;
        logic       len_back;
        logic       step_back;
        logic       step_fwd;
        logic       save;
        logic       load_acc;
        logic       mul;
        logic [3:0] k;
        logic       load_out;
        logic [1:0] out_kind;
        logic [1:0] axis_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_nz;
        logic back_ok;
        logic fwd_ok;
        logic oor;
        logic out_free;
    } t_dp_stat;

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
        logic signed [SUM_W-1:0] res;
        if (v[SUM_W] != v[SUM_W-1]) begin
            res = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            res = v[SUM_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/track_position_to_world_unit.sv]
// Track position to world unit: segment table lookup with sticky cursors.
// Depends on tptw_pkg, tptw_ctrl, tptw_dp (which holds the tptw_ram tables).
//
// Usage:
//   Slave stream carries requests: tuser = op; tdata = segment index, word
//   select, word data, along, lateral, height. Op 0 writes one table word,
//   op 1 is a position query, op 2 an orientation query, op 3 is dropped.
//   Master stream returns results; tuser = out-of-range flag, tlast marks
//   the final result of a request. segment_count is written via i_cfg_we.
// Sequence:
//   A table write is applied as the request is accepted. A position query
//   walks the cursor segment by segment, each step waiting on a registered
//   read of the length table, and the nine products go through one shared
//   32x32 multiplier. An orientation query walks its cursor the same way,
//   then hands its three results to the output register in turn.
// Reset: both cursors go to segment 0 with zero sum, segment_count to 0, the
//   output register empties. Table contents are undefined until written.
// Stall: results sit in an output register; a new request is taken once the
//   previous one has handed all of its results to that register, and the
//   unit holds in place while the receiver keeps tready low.
`default_nettype none
module track_position_to_world_unit #(
    parameter int MAX_SEGMENTS = 64,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tptw_pkg::IDX_W-1:0]      i_cfg_wdata,   // segment_count
    input  wire logic                            i_s_tvalid,
    output      logic                            o_s_tready,
    // [5:0] seg_index, [9:6] word_sel, [41:10] word_data, [73:42] along_pos,
    // [105:74] lateral_pos, [137:106] height_pos, rest zero
    input  wire logic [tptw_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [tptw_pkg::OP_W-1:0]       i_s_tuser,     // [1:0] op
    output      logic                            o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [31:0] vec_x, [63:32] vec_y, [95:64] vec_z, [102:96] found_segment, rest zero
    output      logic [tptw_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output      logic [0:0]                      o_m_tuser,     // [0] out_of_range
    output      logic                            o_m_tlast
);

    tptw_pkg::t_dp_cmd  w_cmd;
    tptw_pkg::t_dp_stat w_stat;

    tptw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (i_s_tuser),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tptw_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_stat.out_free)
        else $error("result loaded over a pending result");

    a_no_mul_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_cmd.mul && !w_cmd.load_out)
        else $error("datapath busy while accepting requests");

    a_step_back_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step_back |-> w_stat.idx_nz)
        else $error("cursor stepped below segment 0");

    a_oor_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast && (o_m_tdata[95:0] == 96'd0))
        else $error("out-of-range result malformed");

endmodule
`default_nettype wire

[rtl/tptw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module tptw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/tptw_ctrl.sv]
// Controller: sequences the cursor walk, the multiply passes and result requests.
// Depends on tptw_pkg for codes and the command/status structs.
`default_nettype none
module tptw_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    output      logic                     o_s_tready,
    input  wire logic [tptw_pkg::OP_W-1:0] i_op,
    input  wire tptw_pkg::t_dp_stat       i_stat,
    output      tptw_pkg::t_dp_cmd        o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_BACK_RD  = 4'd1;
    localparam logic [3:0] S_BACK_CMP = 4'd2;
    localparam logic [3:0] S_FWD_RD   = 4'd3;
    localparam logic [3:0] S_FWD_ADD  = 4'd4;
    localparam logic [3:0] S_DECIDE   = 4'd5;
    localparam logic [3:0] S_MUL      = 4'd6;
    localparam logic [3:0] S_MUL_END  = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;

    logic [3:0] r_state, n_state;
    logic [3:0] r_k, n_k;
    logic [1:0] r_n, n_n;
    logic [1:0] r_kind, n_kind;
    logic       r_orient, n_orient;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_n      = r_n;
        n_kind   = r_kind;
        n_orient = r_orient;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == tptw_pkg::OP_WRITE) begin
                        o_cmd.write = 1'b1;
                    end else if (i_op == tptw_pkg::OP_POS || i_op == tptw_pkg::OP_ORIENT) begin
                        o_cmd.start     = 1'b1;
                        o_cmd.is_orient = (i_op == tptw_pkg::OP_ORIENT);
                        n_orient        = (i_op == tptw_pkg::OP_ORIENT);
                        n_state         = S_BACK_RD;
                    end
                end
            end
            S_BACK_RD: begin
                if (i_stat.idx_nz) begin
                    o_cmd.len_back = 1'b1;
                    n_state        = S_BACK_CMP;
                end else begin
                    n_state = S_FWD_RD;
                end
            end
            S_BACK_CMP: begin
                if (i_stat.back_ok) begin
                    o_cmd.step_back = 1'b1;
                    n_state         = S_BACK_RD;
                end else begin
                    n_state = S_FWD_RD;
                end
            end
            S_FWD_RD: begin
                if (i_stat.fwd_ok) begin
                    n_state = S_FWD_ADD;
                end else begin
                    o_cmd.save = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_FWD_ADD: begin
                o_cmd.step_fwd = 1'b1;
                n_state        = S_FWD_RD;
            end
            S_DECIDE: begin
                if (i_stat.oor) begin
                    n_kind  = tptw_pkg::OUT_OOR;
                    n_state = S_EMIT;
                end else if (r_orient) begin
                    n_kind  = tptw_pkg::OUT_AXIS;
                    n_n     = '0;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.load_acc = 1'b1;
                    n_k            = '0;
                    n_state        = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.k   = r_k;
                if (r_k == tptw_pkg::LAST_TERM) begin
                    n_state = S_MUL_END;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            S_MUL_END: begin
                n_kind  = tptw_pkg::OUT_POS;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = r_kind;
                    o_cmd.axis_sel = r_n;
                    if (r_kind == tptw_pkg::OUT_AXIS && r_n != tptw_pkg::LAST_AXIS) begin
                        n_n = r_n + 2'd1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_n      <= '0;
            r_kind   <= tptw_pkg::OUT_OOR;
            r_orient <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_n      <= n_n;
            r_kind   <= n_kind;
            r_orient <= n_orient;
        end
    end

endmodule
`default_nettype wire

[rtl/tptw_dp.sv]
// Datapath: segment tables, cursors, shared multiplier, accumulators, output register.
// Depends on tptw_pkg and tptw_ram.
`default_nettype none
module tptw_dp #(
    parameter int MAX_SEGMENTS = 64,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tptw_pkg::IDX_W-1:0]      i_cfg_wdata,
    input  wire logic [tptw_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  wire tptw_pkg::t_dp_cmd               i_cmd,
    output      tptw_pkg::t_dp_stat              o_stat,
    input  wire logic                            i_m_tready,
    output      logic                            o_m_tvalid,
    output      logic [tptw_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output      logic [0:0]                      o_m_tuser,
    output      logic                            o_m_tlast
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int DW = tptw_pkg::DATA_W;
    localparam int IW = tptw_pkg::IDX_W;
    localparam int SW = tptw_pkg::SUM_W;
    localparam int CW = tptw_pkg::ACC_W;

    // input fields
    logic        [tptw_pkg::SEG_W-1:0] w_seg;
    logic        [tptw_pkg::SEL_W-1:0] w_sel;
    logic        [DW-1:0]              w_wdata;
    logic signed [DW-1:0]              w_along, w_lat, w_hgt;

    assign w_seg   = i_s_tdata[tptw_pkg::S_SEG_LO +: tptw_pkg::SEG_W];
    assign w_sel   = i_s_tdata[tptw_pkg::S_SEL_LO +: tptw_pkg::SEL_W];
    assign w_wdata = i_s_tdata[tptw_pkg::S_DATA_LO +: DW];
    assign w_along = i_s_tdata[tptw_pkg::S_ALNG_LO +: DW];
    assign w_lat   = i_s_tdata[tptw_pkg::S_LAT_LO +: DW];
    assign w_hgt   = i_s_tdata[tptw_pkg::S_HGT_LO +: DW];

    // configuration and cursors
    logic        [IW-1:0] r_cnt, w_eff;
    logic        [IW-1:0] r_pos_idx, r_ori_idx, r_idx;
    logic signed [SW-1:0] r_pos_sum, r_ori_sum, r_sum;
    logic                 r_orient;
    logic signed [DW-1:0] r_x, r_y, r_z, r_d;

    assign w_eff = (32'(r_cnt) > 32'(MAX_SEGMENTS)) ? IW'(MAX_SEGMENTS) : r_cnt;

    // table storage
    logic                 w_wr;
    logic        [AW-1:0] w_waddr, w_raddr, w_len_raddr;
    logic signed [DW-1:0] w_len;
    logic signed [DW-1:0] w_org [3];
    logic signed [DW-1:0] w_ax  [9];

    assign w_wr    = i_cmd.write && ({26'd0, w_seg} < 32'(MAX_SEGMENTS))
                     && (w_sel <= tptw_pkg::SEL_LAST);
    assign w_waddr = AW'(w_seg);
    assign w_raddr = AW'(r_idx);
    assign w_len_raddr = i_cmd.len_back ? AW'(r_idx - 7'd1) : AW'(r_idx);

    tptw_ram #(.WIDTH(DW), .DEPTH(MAX_SEGMENTS)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr && (w_sel == tptw_pkg::SEL_LENGTH)),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_len_raddr),
        .o_rdata (w_len)
    );

    for (genvar c = 0; c < 3; c++) begin : g_org
        tptw_ram #(.WIDTH(DW), .DEPTH(MAX_SEGMENTS)) u_org_ram (
            .i_clk   (i_clk),
            .i_we    (w_wr && (w_sel == tptw_pkg::SEL_ORIGIN + 4'(c))),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_raddr (w_raddr),
            .o_rdata (w_org[c])
        );
    end

    for (genvar a = 0; a < 9; a++) begin : g_ax
        tptw_ram #(.WIDTH(DW), .DEPTH(MAX_SEGMENTS)) u_ax_ram (
            .i_clk   (i_clk),
            .i_we    (w_wr && (w_sel == tptw_pkg::SEL_AXIS + 4'(a))),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_raddr (w_raddr),
            .o_rdata (w_ax[a])
        );
    end

    // cursor walk
    logic signed [SW:0]   w_diff;
    logic signed [SW-1:0] w_sum_back, w_sum_fwd;

    assign w_diff     = (SW+1)'(r_sum) - (SW+1)'(r_x);
    assign w_sum_back = tptw_pkg::sat_sum((SW+1)'(r_sum) - (SW+1)'(w_len));
    assign w_sum_fwd  = tptw_pkg::sat_sum((SW+1)'(r_sum) + (SW+1)'(w_len));

    assign o_stat.idx_nz   = (r_idx != '0);
    assign o_stat.back_ok  = (w_diff >= (SW+1)'(w_len));
    assign o_stat.fwd_ok   = (r_sum < SW'(r_x)) && (r_idx < w_eff);
    assign o_stat.oor      = (r_idx >= w_eff);
    assign o_stat.out_free = !o_m_tvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_pos_idx <= '0;
            r_pos_sum <= '0;
            r_ori_idx <= '0;
            r_ori_sum <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cnt <= i_cfg_wdata;
            end
            if (i_cmd.save) begin
                if (r_orient) begin
                    r_ori_idx <= r_idx;
                    r_ori_sum <= r_sum;
                end else begin
                    r_pos_idx <= r_idx;
                    r_pos_sum <= r_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_orient <= i_cmd.is_orient;
            r_idx    <= i_cmd.is_orient ? r_ori_idx : r_pos_idx;
            r_sum    <= i_cmd.is_orient ? r_ori_sum : r_pos_sum;
            r_x      <= w_along;
            r_y      <= w_lat;
            r_z      <= w_hgt;
        end else if (i_cmd.step_back) begin
            r_idx <= r_idx - 7'd1;
            r_sum <= w_sum_back;
        end else if (i_cmd.step_fwd) begin
            r_idx <= r_idx + 7'd1;
            r_sum <= w_sum_fwd;
        end
        if (i_cmd.load_acc) begin
            r_d <= tptw_pkg::sat_word(CW'(r_x) - CW'(r_sum));
        end
    end

    // shared multiplier: term 0 along offset into the segment, 1 lateral (subtracted), 2 height
    logic        [1:0]    w_term, w_comp;
    logic signed [DW-1:0] w_mul_a;
    logic signed [CW-1:0] r_prod;
    logic        [1:0]    r_prod_term, r_prod_comp;
    logic                 r_prod_v;
    logic signed [CW-1:0] r_acc [3];
    logic signed [CW-1:0] w_term_val;

    always_comb begin
        case (i_cmd.k)
            4'd0:    begin w_term = 2'd0; w_comp = 2'd0; end
            4'd1:    begin w_term = 2'd0; w_comp = 2'd1; end
            4'd2:    begin w_term = 2'd0; w_comp = 2'd2; end
            4'd3:    begin w_term = 2'd1; w_comp = 2'd0; end
            4'd4:    begin w_term = 2'd1; w_comp = 2'd1; end
            4'd5:    begin w_term = 2'd1; w_comp = 2'd2; end
            4'd6:    begin w_term = 2'd2; w_comp = 2'd0; end
            4'd7:    begin w_term = 2'd2; w_comp = 2'd1; end
            default: begin w_term = 2'd2; w_comp = 2'd2; end
        endcase
        case (w_term)
            2'd0:    w_mul_a = r_d;
            2'd1:    w_mul_a = r_y;
            default: w_mul_a = r_z;
        endcase
    end

    assign w_term_val = r_prod >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_cmd.mul;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= w_mul_a * w_ax[i_cmd.k];
        r_prod_term <= w_term;
        r_prod_comp <= w_comp;
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.load_acc) begin
                r_acc[c] <= CW'(w_org[c]);
            end else if (r_prod_v && r_prod_comp == 2'(c)) begin
                if (r_prod_term == 2'd1) begin
                    r_acc[c] <= r_acc[c] - w_term_val;
                end else begin
                    r_acc[c] <= r_acc[c] + w_term_val;
                end
            end
        end
    end

    // output register
    logic                 r_o_valid;
    logic signed [DW-1:0] r_o_x, r_o_y, r_o_z;
    logic        [IW-1:0] r_o_seg;
    logic                 r_o_oor, r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_seg <= r_idx;
            case (i_cmd.out_kind)
                tptw_pkg::OUT_POS: begin
                    r_o_x    <= tptw_pkg::sat_word(r_acc[0]);
                    r_o_y    <= tptw_pkg::sat_word(r_acc[1]);
                    r_o_z    <= tptw_pkg::sat_word(r_acc[2]);
                    r_o_oor  <= 1'b0;
                    r_o_last <= 1'b1;
                end
                tptw_pkg::OUT_AXIS: begin
                    case (i_cmd.axis_sel)
                        2'd0: begin
                            r_o_x <= w_ax[0]; r_o_y <= w_ax[1]; r_o_z <= w_ax[2];
                        end
                        2'd1: begin
                            r_o_x <= w_ax[3]; r_o_y <= w_ax[4]; r_o_z <= w_ax[5];
                        end
                        default: begin
                            r_o_x <= w_ax[6]; r_o_y <= w_ax[7]; r_o_z <= w_ax[8];
                        end
                    endcase
                    r_o_oor  <= 1'b0;
                    r_o_last <= (i_cmd.axis_sel == tptw_pkg::LAST_AXIS);
                end
                default: begin
                    r_o_x    <= '0;
                    r_o_y    <= '0;
                    r_o_z    <= '0;
                    r_o_oor  <= 1'b1;
                    r_o_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{tptw_pkg::M_PAD_W{1'b0}}, r_o_seg, r_o_z, r_o_y, r_o_x};
    assign o_m_tuser  = r_o_oor;
    assign o_m_tlast  = r_o_last;

endmodule
`default_nettype wire

[test/track_position_to_world_unit_tb.sv]
// Self-checking testbench for track_position_to_world_unit: loads the segment table,
// runs directed and random position/orientation requests and checks each result.
// Depends on tptw_pkg and the RTL of track_position_to_world_unit.
module track_position_to_world_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tptw_pkg::*;

    localparam int SEG_MAX      = 64;
    localparam int FRAC         = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 300;
    localparam int CFG_SETTLE   = 30;
    localparam int STUCK_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 35;
    localparam longint SUM_HI  = 64'sd549755813887;
    localparam longint SUM_LO  = -64'sd549755813888;
    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483648;
    localparam logic [OP_W-1:0] OP_DROP = 2'd3;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [SEG_W-1:0]         seg;
        logic [SEL_W-1:0]         sel;
        logic signed [DATA_W-1:0] data;
        logic signed [DATA_W-1:0] along;
        logic signed [DATA_W-1:0] lateral;
        logic signed [DATA_W-1:0] height;
    } track_request_t;

    typedef struct {
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] vz;
        logic [IDX_W-1:0]         seg;
        logic                     oor;
        logic                     last;
    } world_result_t;

    class track_lookup_board;
        logic [IDX_W-1:0] seg_count;
        int               len_tab[SEG_MAX];
        int               org_tab[SEG_MAX*3];
        int               axis_tab[SEG_MAX*9];
        int unsigned      cur_idx[2];
        longint           cur_sum[2];
        world_result_t    pending_results[$];
        int               mismatches;

        function new();
            seg_count = '0;
            mismatches = 0;
            foreach (len_tab[i]) len_tab[i] = 0;
            foreach (org_tab[i]) org_tab[i] = 0;
            foreach (axis_tab[i]) axis_tab[i] = 0;
            cur_idx[0] = 0;
            cur_idx[1] = 0;
            cur_sum[0] = 0;
            cur_sum[1] = 0;
        endfunction

        function int unsigned live_count();
            return (seg_count > SEG_MAX) ? SEG_MAX : int'(seg_count);
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint seg_start(int unsigned n);
            longint acc;
            acc = 0;
            for (int i = 0; i < n; i++) acc += len_tab[i];
            return acc;
        endfunction

        // back off while the whole previous segment lies ahead of the target, then advance
        function void walk_cursor(int k, longint along);
            int unsigned cnt;
            cnt = live_count();
            while (cur_idx[k] > 0 && cur_sum[k] - along >= longint'(len_tab[cur_idx[k]-1])) begin
                cur_sum[k] = clamp(cur_sum[k] - len_tab[cur_idx[k]-1], SUM_LO, SUM_HI);
                cur_idx[k]--;
            end
            while (cur_sum[k] < along && cur_idx[k] < cnt) begin
                cur_sum[k] = clamp(cur_sum[k] + len_tab[cur_idx[k]], SUM_LO, SUM_HI);
                cur_idx[k]++;
            end
        endfunction

        function void push(longint x, longint y, longint z, int unsigned s, bit oor, bit last);
            world_result_t r;
            r.vx = DATA_W'(x);
            r.vy = DATA_W'(y);
            r.vz = DATA_W'(z);
            r.seg = IDX_W'(s);
            r.oor = oor;
            r.last = last;
            pending_results.push_back(r);
        endfunction

        function void note_request(track_request_t rq);
            int unsigned s;
            longint d;
            longint acc;
            longint r[3];
            case (rq.op)
                OP_WRITE: begin
                    if (rq.sel == SEL_LENGTH) begin
                        len_tab[rq.seg] = rq.data;
                    end else if (rq.sel < SEL_AXIS) begin
                        org_tab[int'(rq.seg)*3 + int'(rq.sel) - int'(SEL_ORIGIN)] = rq.data;
                    end else if (rq.sel <= SEL_LAST) begin
                        axis_tab[int'(rq.seg)*9 + int'(rq.sel) - int'(SEL_AXIS)] = rq.data;
                    end
                end
                OP_POS: begin
                    walk_cursor(0, rq.along);
                    s = cur_idx[0];
                    if (s >= live_count()) begin
                        push(0, 0, 0, s, 1'b1, 1'b1);
                    end else begin
                        d = clamp(longint'(rq.along) - cur_sum[0], WORD_LO, WORD_HI);
                        for (int c = 0; c < 3; c++) begin
                            acc = org_tab[s*3 + c];
                            acc += (d * axis_tab[s*9 + c]) >>> FRAC;
                            acc -= (longint'(rq.lateral) * axis_tab[s*9 + 3 + c]) >>> FRAC;
                            acc += (longint'(rq.height) * axis_tab[s*9 + 6 + c]) >>> FRAC;
                            r[c] = clamp(acc, WORD_LO, WORD_HI);
                        end
                        push(r[0], r[1], r[2], s, 1'b0, 1'b1);
                    end
                end
                OP_ORIENT: begin
                    walk_cursor(1, rq.along);
                    s = cur_idx[1];
                    if (s >= live_count()) begin
                        push(0, 0, 0, s, 1'b1, 1'b1);
                    end else begin
                        for (int a = 0; a < 3; a++) begin
                            push(axis_tab[s*9 + a*3], axis_tab[s*9 + a*3 + 1],
                                 axis_tab[s*9 + a*3 + 2], s, 1'b0, a == 2);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(world_result_t got);
            world_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: x %h y %h z %h seg %0d oor %0b last %0b",
                             got.vx, got.vy, got.vz, got.seg, got.oor, got.last);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
                got.seg !== want.seg || got.oor !== want.oor || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp x %h y %h z %h seg %0d oor %0b last %0b",
                             want.vx, want.vy, want.vz, want.seg, want.oor, want.last);
                    $display("          got x %h y %h z %h seg %0d oor %0b last %0b",
                             got.vx, got.vy, got.vz, got.seg, got.oor, got.last);
                end
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [IDX_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata = '0;
    logic [OP_W-1:0]        i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic [0:0]             o_m_tuser;
    logic                   o_m_tlast;

    track_lookup_board board = new();
    bit     send_idle = 1'b1;
    bit     recv_idle = 1'b1;
    bit     hold_request = 1'b0;
    longint path_pos[2] = '{0, 0};

    track_position_to_world_unit #(
        .MAX_SEGMENTS(SEG_MAX),
        .FRAC_BITS   (FRAC)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table contents: mostly short segments and small axes, a few extreme words
    function automatic int table_word(int seg, int sel);
        if (sel == SEL_LENGTH) begin
            if (seg == 5) return 0;
            if (seg == 9) return -16384;
            if (seg == SEG_MAX - 1) return 32'h7FFF_FFFF;
            return $urandom_range(32768, 262144);
        end
        if (sel < SEL_AXIS) begin
            if (seg == 7) return 32'h7FFF_FFFF;
            if (seg == 8) return 32'h8000_0000;
            return int'($urandom_range(0, 1 << 25)) - (1 << 24);
        end
        if (seg == 3) return (sel % 2 != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return int'($urandom_range(0, 1 << 18)) - (1 << 17);
    endfunction

    task automatic send_request(input track_request_t rq);
        int gap;
        logic [S_TDATA_W-1:0] word;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        word = '0;
        word[S_SEG_LO +: SEG_W]  = rq.seg;
        word[S_SEL_LO +: SEL_W]  = rq.sel;
        word[S_DATA_LO +: DATA_W] = rq.data;
        word[S_ALNG_LO +: DATA_W] = rq.along;
        word[S_LAT_LO +: DATA_W]  = rq.lateral;
        word[S_HGT_LO +: DATA_W]  = rq.height;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= rq.op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_request(rq);
    endtask

    task automatic query(input logic [OP_W-1:0] op, input longint along,
                         input int lateral, input int height);
        track_request_t rq;
        rq = '{default: '0};
        rq.op = op;
        rq.along = DATA_W'(board.clamp(along, WORD_LO, WORD_HI));
        rq.lateral = lateral;
        rq.height = height;
        send_request(rq);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_segment_count(input logic [IDX_W-1:0] cnt);
        wait_drained();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cnt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.seg_count = cnt;
    endtask

    task automatic fill_table();
        track_request_t rq;
        rq = '{default: '0};
        rq.op = OP_WRITE;
        for (int s = 0; s < SEG_MAX; s++) begin
            for (int w = 0; w <= int'(SEL_LAST); w++) begin
                rq.seg  = SEG_W'(s);
                rq.sel  = SEL_W'(w);
                rq.data = table_word(s, w);
                send_request(rq);
            end
        end
    endtask

    task automatic run_directed();
        track_request_t rq;
        rq = '{default: '0};
        // count still zero from reset
        query(OP_POS, 0, 0, 0);
        query(OP_ORIENT, 65536, 0, 0);
        set_segment_count(SEG_MAX);
        query(OP_POS, 0, 0, 0);
        query(OP_POS, WORD_HI, 32'sh8000_0000, 32'sh7FFF_FFFF);
        query(OP_ORIENT, WORD_HI, 0, 0);
        query(OP_POS, WORD_LO, 32'sh7FFF_FFFF, 32'sh8000_0000);
        query(OP_ORIENT, WORD_LO, 0, 0);
        query(OP_POS, board.seg_start(3) + 1000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        query(OP_POS, board.seg_start(7) + 500, 1 << 20, -(1 << 20));
        query(OP_POS, board.seg_start(8) + 500, -(1 << 20), 1 << 20);
        query(OP_POS, board.seg_start(5), 0, 0);
        query(OP_ORIENT, board.seg_start(9) + 10, 0, 0);
        rq.op = OP_DROP;
        rq.along = 32'sh7FFF_FFFF;
        send_request(rq);
        rq.op = OP_WRITE;
        rq.seg = SEG_W'(SEG_MAX - 1);
        rq.sel = SEL_W'(15);
        rq.data = 32'sh5555_AAAA;
        send_request(rq);
        rq.sel = SEL_LAST;
        rq.data = table_word(SEG_MAX - 1, SEL_LAST);
        send_request(rq);
        set_segment_count(7'd127);
        query(OP_ORIENT, WORD_HI, 0, 0);
        set_segment_count(SEG_MAX);
        query(OP_POS, board.seg_start(40) + 100, 0, 0);
        // count below the cursor: out of range until a query walks it back
        set_segment_count(7'd10);
        query(OP_POS, board.seg_start(40) + 200, 0, 0);
        query(OP_POS, 1000, 4096, -4096);
    endtask

    function automatic bit make_random_request(output track_request_t rq);
        int unsigned roll;
        int unsigned cnt;
        int k;
        longint span;
        roll = $urandom_range(0, 99);
        rq.op      = OP_WRITE;
        rq.seg     = SEG_W'($urandom);
        rq.sel     = SEL_W'($urandom);
        rq.data    = $urandom;
        rq.along   = $urandom;
        rq.lateral = $urandom;
        rq.height  = $urandom;
        if (roll < 70) begin
            k = $urandom_range(0, 1);
            rq.op = (k == 0) ? OP_POS : OP_ORIENT;
            cnt = board.live_count();
            span = board.seg_start(cnt);
            path_pos[k] += longint'($urandom_range(0, 100000)) - 40000;
            if (path_pos[k] < -65536 || path_pos[k] > span + 65536 ||
                $urandom_range(0, 19) == 0) begin
                path_pos[k] = board.seg_start(cnt == 0 ? 0 : $urandom_range(0, cnt - 1))
                              + $urandom_range(0, 65535);
            end
            rq.along = DATA_W'(board.clamp(path_pos[k], WORD_LO, WORD_HI));
            if ($urandom_range(0, 9) != 0) begin
                rq.lateral = int'($urandom_range(0, 1 << 19)) - (1 << 18);
                rq.height  = int'($urandom_range(0, 1 << 19)) - (1 << 18);
            end
            return 1'b1;
        end
        if (roll < 85) begin
            if (rq.sel == SEL_LENGTH || $urandom_range(0, 9) != 0) begin
                rq.data = table_word(rq.seg, rq.sel);
            end
            return rq.sel <= SEL_LAST;
        end
        if (roll < 93) begin
            rq.op = ($urandom_range(0, 1) != 0) ? OP_POS : OP_ORIENT;
            return 1'b1;
        end
        rq.op = OP_DROP;
        return 1'b0;
    endfunction

    task automatic run_random();
        track_request_t rq;
        logic [IDX_W-1:0] cnt;
        int counted;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0, 5, 7: cnt = SEG_MAX;
                1:       cnt = 7'd127;
                2:       cnt = 7'd1;
                4:       cnt = 7'd0;
                default: cnt = IDX_W'($urandom_range(2, SEG_MAX - 1));
            endcase
            set_segment_count(cnt);
            send_idle = (ph % 3) != 2;
            recv_idle = (ph % 4) != 3;
            if (ph == 1 || ph == 5) hold_request = 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if (make_random_request(rq)) counted++;
                send_request(rq);
            end
        end
    endtask

    initial begin : result_sink
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = recv_idle ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        world_result_t got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.vx   = o_m_tdata[0 +: DATA_W];
            got.vy   = o_m_tdata[DATA_W +: DATA_W];
            got.vz   = o_m_tdata[2*DATA_W +: DATA_W];
            got.seg  = o_m_tdata[3*DATA_W +: IDX_W];
            got.oor  = o_m_tuser[0];
            got.last = o_m_tlast;
            board.check_result(got);
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("track_position_to_world_unit_tb NOT OK");
        $finish;
    end

    initial begin : main_flow
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fill_table();
        run_directed();
        run_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("track_position_to_world_unit_tb OK");
        end else begin
            $display("track_position_to_world_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
